// ===== rtl/lzbp_pkg.sv =====
// Package for the LSB-first pair bit packer.
// Holds the word types, size constants and action codes shared by all rtl/ modules.
// No dependencies.
package lzbp_pkg;

  localparam int CODE_WIDTH   = 16;
  localparam int SYMBOL_WIDTH = 8;
  localparam int BYTE_BITS    = 8;
  localparam int NBITS_WIDTH  = 5;
  localparam int PEND_WIDTH   = BYTE_BITS - 1;
  localparam int PCNT_WIDTH   = 3;
  localparam int ACC_WIDTH    = PEND_WIDTH + CODE_WIDTH + SYMBOL_WIDTH;
  localparam int MAX_BYTES    = ACC_WIDTH / BYTE_BITS;
  localparam int JOB_BITS     = MAX_BYTES * BYTE_BITS;
  localparam int CNT_WIDTH    = $clog2(MAX_BYTES + 1);
  localparam int POS_WIDTH    = $clog2(ACC_WIDTH + 1);

  localparam logic ACT_PAIR  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [CODE_WIDTH-1:0]  code_value;
    logic [7:0]             symbol_byte;
    logic [NBITS_WIDTH-1:0] code_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
  } out_word_t;

  // Up to MAX_BYTES finished bytes of one item, earliest byte in the low bits.
  typedef struct packed {
    logic [JOB_BITS-1:0]  bytes;
    logic [CNT_WIDTH-1:0] count;
  } job_t;

endpackage

// ===== rtl/lz_pair_bit_packer.sv =====
// Top level of the LSB-first pair bit packer.
// Depends on lzbp_pkg, lzbp_front, lzbp_job_fifo and lzbp_back.
//
// This block packs (code, symbol) pairs into a byte stream, least significant
// bit first. A pair word appends the low code_bits bits of code_value (values
// above 16 count as 16) and then the 8 bits of symbol_byte to a bit
// accumulator; every finished byte comes out as one result word, and the last
// byte caused by an input word carries last_of_item. A flush word sends out the
// partial byte, zero-padded in its high bits, and clears the accumulator; a
// flush with nothing pending produces no result. The input side takes one word
// per cycle while the two-entry job queue has room. The result side delivers
// one byte per cycle while pop is held, so a pair yields one to three result
// words and a flush zero or one; the sustained rate is set by that byte-wide
// result port. The first result can be popped in the cycle after its input
// word is accepted.
module lz_pair_bit_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lzbp_pkg::in_word_t  item,
  output logic                empty,
  input  logic                pop,
  output lzbp_pkg::out_word_t result
);
  import lzbp_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  job_t head;
  logic head_done;

  // A word is taken whenever the queue has a free entry; the front end
  // updates its leftover bits in the same cycle.
  assign accept = push && !full;

  lzbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (job_valid),
    .job       (job)
  );

  // Jobs with no bytes never enter the queue, so every queued job yields
  // at least one result word.
  lzbp_job_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_valid),
    .wr_job (job),
    .rd     (head_done),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  lzbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (empty),
    .pop        (pop),
    .head_done  (head_done),
    .result     (result)
  );

endmodule

// ===== rtl/lzbp_front.sv =====
// Front end of the pair bit packer: accepts words, keeps the leftover bits,
// and turns each word into a job of finished bytes. Depends on lzbp_pkg.
module lzbp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lzbp_pkg::in_word_t item,
  output logic              job_valid,
  output lzbp_pkg::job_t    job
);
  import lzbp_pkg::*;

  logic [PEND_WIDTH-1:0]  pending_bits, pending_bits_next;
  logic [PCNT_WIDTH-1:0]  pending_count, pending_count_next;

  logic [NBITS_WIDTH-1:0] nbits;
  logic [CODE_WIDTH-1:0]  code_m;
  logic [POS_WIDTH-1:0]   sym_pos;
  logic [POS_WIDTH-1:0]   total;
  logic [ACC_WIDTH-1:0]   acc;
  logic [ACC_WIDTH-1:0]   acc_rest;
  logic [CNT_WIDTH-1:0]   nbytes;

  always_comb begin
    if (item.code_bits > NBITS_WIDTH'(CODE_WIDTH)) begin
      nbits = NBITS_WIDTH'(CODE_WIDTH);
    end else begin
      nbits = item.code_bits;
    end
    code_m  = item.code_value & ~({CODE_WIDTH{1'b1}} << nbits);
    sym_pos = POS_WIDTH'(pending_count) + POS_WIDTH'(nbits);
    total   = sym_pos + POS_WIDTH'(SYMBOL_WIDTH);
    acc     = ACC_WIDTH'(pending_bits)
            | (ACC_WIDTH'(code_m) << pending_count)
            | (ACC_WIDTH'(item.symbol_byte[SYMBOL_WIDTH-1:0]) << sym_pos);
    nbytes  = CNT_WIDTH'(total / BYTE_BITS);
    acc_rest = acc >> (nbytes * BYTE_BITS);

    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    job_valid          = 1'b0;
    job.bytes          = acc[JOB_BITS-1:0];
    job.count          = nbytes;

    if (accept) begin
      if (item.action == ACT_FLUSH) begin
        job.bytes          = JOB_BITS'(pending_bits);
        job.count          = CNT_WIDTH'(1);
        job_valid          = (pending_count != '0);
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else begin
        job_valid          = (nbytes != '0);
        pending_count_next = total[PCNT_WIDTH-1:0];
        pending_bits_next  = acc_rest[PEND_WIDTH-1:0]
                           & ~({PEND_WIDTH{1'b1}} << total[PCNT_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== rtl/lzbp_job_fifo.sv =====
// Two-entry job queue between the front end and the byte serializer.
// Depends on lzbp_pkg.
module lzbp_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lzbp_pkg::job_t wr_job,
  input  logic           rd,
  output lzbp_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import lzbp_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/lzbp_back.sv =====
// Back end of the pair bit packer: hands out the bytes of the head job one
// word at a time and retires the job after its last byte. Depends on lzbp_pkg.
module lzbp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lzbp_pkg::job_t       head,
  input  logic                 head_empty,
  input  logic                 pop,
  output logic                 head_done,
  output lzbp_pkg::out_word_t  result
);
  import lzbp_pkg::*;

  logic [CNT_WIDTH-1:0] idx;
  logic                 is_last;
  logic                 take;

  assign is_last   = (idx == head.count - CNT_WIDTH'(1));
  assign take      = pop && !head_empty;
  assign head_done = take && is_last;

  always_comb begin
    result.out_byte     = 8'(head.bytes >> (idx * BYTE_BITS));
    result.last_of_item = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      if (is_last) begin
        idx <= '0;
      end else begin
        idx <= idx + CNT_WIDTH'(1);
      end
    end
  end

endmodule

// ===== sim/lz_pair_bit_packer_tb.sv =====
// Self-checking testbench for lz_pair_bit_packer: directed and random pair/flush words.
// Expected bytes come from a bit-accurate packing model kept inside this file.
// Depends on rtl/lzbp_pkg.sv and rtl/lz_pair_bit_packer.sv.
`timescale 1ns / 100ps

module lz_pair_bit_packer_tb;
  import lzbp_pkg::*;

  // One entry of the stimulus list. A word marked wait_drain is held back
  // until every byte expected so far has been popped.
  typedef struct {
    in_word_t word;
    bit       wait_drain;
  } stim_word_t;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_word_t  item;
  logic      empty;
  logic      pop;
  out_word_t result;

  stim_word_t stim_q[$];
  out_word_t  expected_bytes[$];

  // Copy of the packer's leftover bits, earliest bit in bit 0.
  logic [PEND_WIDTH-1:0] pack_bits;
  logic [PCNT_WIDTH-1:0] pack_cnt;

  int  err_count;
  int  accepted_cnt;
  int  hold_left;
  bit  hold_done;
  bit  send_idle;
  logic steady;

  lz_pair_bit_packer u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // A window of words during which neither side idles at random, so the block also
  // runs back to back at its full rate.
  assign steady = (accepted_cnt >= 220) && (accepted_cnt < 320);

  // Works out the bytes that one accepted word causes and queues them in
  // order. Updates the leftover-bit state the same way the block must.
  task automatic pack_word(input in_word_t w);
    logic [31:0] acc;
    logic [31:0] code_mask;
    out_word_t   r;
    int          nbits;
    int          total;
    if (w.action == ACT_FLUSH) begin
      // A flush sends the partial byte, zero-padded, only if bits are waiting.
      if (pack_cnt != 0) begin
        r.out_byte     = {1'b0, pack_bits};
        r.last_of_item = 1'b1;
        expected_bytes.push_back(r);
      end
      pack_bits = '0;
      pack_cnt  = '0;
      return;
    end
    // Code lengths past the code width saturate.
    nbits = (w.code_bits > CODE_WIDTH) ? CODE_WIDTH : int'(w.code_bits);
    code_mask = (32'h1 << nbits) - 32'h1;
    acc = {25'b0, pack_bits};
    acc |= ({16'b0, w.code_value} & code_mask) << pack_cnt;
    acc |= {24'b0, w.symbol_byte} << (int'(pack_cnt) + nbits);
    total = int'(pack_cnt) + nbits + SYMBOL_WIDTH;
    while (total >= BYTE_BITS) begin
      r.out_byte     = acc[7:0];
      r.last_of_item = (total - BYTE_BITS) < BYTE_BITS;
      expected_bytes.push_back(r);
      acc   = acc >> BYTE_BITS;
      total = total - BYTE_BITS;
    end
    pack_cnt  = total[PCNT_WIDTH-1:0];
    pack_bits = acc[PEND_WIDTH-1:0];
  endtask

  task automatic add_word(input logic act, input logic [15:0] code, input logic [7:0] sym,
                          input logic [4:0] nbits, input bit drain);
    stim_word_t s;
    s.word.action      = act;
    s.word.code_value  = code;
    s.word.symbol_byte = sym;
    s.word.code_bits   = nbits;
    s.wait_drain       = drain;
    stim_q.push_back(s);
  endtask

  // Sender: presents the head of the stimulus list at each falling edge,
  // skipping a cycle now and then, and holding a drain-marked word back
  // until the result side has caught up.
  always @(negedge clk) begin
    if (rst || stim_q.size() == 0) begin
      push <= 1'b0;
    end else if (stim_q[0].wait_drain && expected_bytes.size() != 0) begin
      push <= 1'b0;
    end else begin
      send_idle = !steady && ($urandom_range(99) < 10);
      push <= !send_idle;
      item <= stim_q[0].word;
    end
  end

  // Receiver: pops most cycles. Once, after some traffic, it holds off for a
  // long stretch so the job queue fills and full pushes back on the sender.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= 80) begin
      hold_done <= 1'b1;
      hold_left <= 119;
      pop       <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= 10);
    end
  end

  // Both handshakes are sampled at the rising edge. A word accepted at this
  // edge cannot have a byte out yet, so the check and the prediction never
  // compete for the same entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result word: out_byte %02h last_of_item %0b",
                 result.out_byte, result.last_of_item);
          err_count++;
        end else begin
          out_word_t want;
          want = expected_bytes.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, result.out_byte);
            err_count++;
          end
          if (result.last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %0b, actual %0b",
                   want.last_of_item, result.last_of_item);
            err_count++;
          end
        end
      end
      if (push && !full) begin
        pack_word(item);
        stim_q.pop_front();
        accepted_cnt++;
      end
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k;
    logic [4:0] nb;
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    item         = '0;
    pack_bits    = '0;
    pack_cnt     = '0;
    err_count    = 0;
    accepted_cnt = 0;
    hold_left    = 0;
    hold_done    = 1'b0;

    // Directed part. A flush straight after reset has nothing to send.
    add_word(ACT_FLUSH, 16'hFFFF, 8'hFF, 5'd31, 1'b0);
    // Zero code length: the code is dropped whatever its value.
    add_word(ACT_PAIR,  16'hFFFF, 8'h00, 5'd0,  1'b0);
    add_word(ACT_PAIR,  16'hFFFF, 8'hFF, 5'd16, 1'b0);
    add_word(ACT_PAIR,  16'h0000, 8'h00, 5'd16, 1'b0);
    // Three bits left over, then a flush that sends them padded.
    add_word(ACT_PAIR,  16'h0005, 8'hA5, 5'd3,  1'b0);
    add_word(ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b0);
    add_word(ACT_FLUSH, 16'h1234, 8'h56, 5'd7,  1'b0);
    // Lengths above sixteen saturate.
    add_word(ACT_PAIR,  16'hFFFF, 8'h00, 5'd17, 1'b0);
    add_word(ACT_PAIR,  16'h1234, 8'h80, 5'd31, 1'b0);
    // Seven pending bits plus a full code and symbol give three bytes.
    add_word(ACT_PAIR,  16'h007F, 8'hFF, 5'd7,  1'b0);
    add_word(ACT_PAIR,  16'hFFFF, 8'hFF, 5'd16, 1'b0);
    add_word(ACT_PAIR,  16'hAAAA, 8'h55, 5'd16, 1'b0);
    add_word(ACT_FLUSH, 16'hFFFF, 8'hFF, 5'd16, 1'b0);
    add_word(ACT_PAIR,  16'h0001, 8'h01, 5'd1,  1'b0);
    add_word(ACT_PAIR,  16'h8000, 8'h7F, 5'd15, 1'b0);
    add_word(ACT_PAIR,  16'h00FF, 8'h00, 5'd8,  1'b0);
    add_word(ACT_FLUSH, 16'h0000, 8'hFF, 5'd0,  1'b0);
    add_word(ACT_PAIR,  16'h5555, 8'hAA, 5'd16, 1'b0);
    add_word(ACT_PAIR,  16'hFFFF, 8'hFF, 5'd20, 1'b0);
    add_word(ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b0);

    // Random part: mostly pairs, with flushes scattered in, and now and
    // then an over-long code length. Two words wait for a full drain.
    for (k = 0; k < 370; k++) begin
      if ($urandom_range(99) < 70) nb = 5'($urandom_range(16));
      else nb = 5'($urandom_range(31, 17));
      add_word(($urandom_range(99) < 15) ? ACT_FLUSH : ACT_PAIR,
               16'($urandom), 8'($urandom), nb, (k == 0) || (k == 200));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    // Run on so that a stray extra byte is still caught.
    repeat (20) @(posedge clk);

    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
